/* hw/rtl/lcht_pkg.sv */
// Shared types and constants for the line envelope tree.
// No dependencies; every other file but lcht_ram imports this package.
`default_nettype none
package lcht_pkg;

  localparam int SIZE    = 1024;
  localparam int IDX_W   = $clog2(SIZE);
  localparam int NODES   = 2 * SIZE - 1;
  localparam int NODE_AW = $clog2(NODES);
  localparam int KW      = IDX_W + 2;
  localparam logic signed [63:0] EMPTY_RESET = 64'sd1000000000000000000;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ADD   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_SELECT_MIN = 1'b0,
    CFG_EMPTY_ICPT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CS_L    = 2'd0,
    CS_M    = 2'd1,
    CS_R    = 2'd2,
    CS_SLOT = 2'd3
  } coord_sel_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE,
    S_A_NODE, S_A_RD, S_A_X, S_A_MN, S_A_MO, S_A_CMP, S_A_DEC,
    S_Q_RD, S_Q_X, S_Q_NODE, S_Q_LD, S_Q_MUL, S_Q_ACC, S_Q_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       clr_start;
    logic       clr_step;
    logic       coord_we;
    logic       ld_item;
    coord_sel_t csel;
    logic       ld_x;
    logic       ld_old;
    logic       mul_old;
    logic       ld_vn;
    logic       ld_flag;
    logic [1:0] flag_idx;
    logic       step;
    logic       q_init;
    logic       q_acc;
    logic       q_up;
    logic       out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic add_stop;
    logic k_zero;
    logic clr_last;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/lcht_if.sv */
// Valid/ready channel interfaces for the line envelope tree.
// Depends on lcht_pkg.
`default_nettype none
interface lcht_in_if import lcht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [9:0]         index;
  logic signed [31:0] coord_value;
  logic signed [31:0] line_slope;
  logic signed [63:0] line_intercept;
  modport source (output valid, cmd, index, coord_value, line_slope, line_intercept,
                  input ready);
  modport sink (input valid, cmd, index, coord_value, line_slope, line_intercept,
                output ready);
endinterface

interface lcht_out_if ();
  logic               valid;
  logic               ready;
  logic signed [63:0] best_value;
  modport source (output valid, best_value, input ready);
  modport sink (input valid, best_value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lcht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lcht_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hw/rtl/lcht_dp.sv */
// Datapath: config registers, node and coordinate memories, shared multiplier.
// Depends on lcht_pkg and lcht_ram.
`default_nettype none
module lcht_dp import lcht_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [63:0]        cfg_wdata,
  input  wire logic [9:0]         in_index,
  input  wire logic signed [31:0] in_coord_value,
  input  wire logic signed [31:0] in_line_slope,
  input  wire logic signed [63:0] in_line_intercept,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic signed [63:0]      out_best_value,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat
);
  // configuration
  logic               sel_min_r;
  logic signed [63:0] empty_icpt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_min_r    <= 1'b1;
      empty_icpt_r <= EMPTY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SELECT_MIN: sel_min_r    <= cfg_wdata[0];
        CFG_EMPTY_ICPT: empty_icpt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // working registers
  logic signed [31:0] ns_r, os_r, x_r;
  logic signed [63:0] ni_r, oi_r, prod_r, vn_r, best_r, clr_icpt_r, out_data_r;
  logic [IDX_W-1:0]   slot_r;
  logic [IDX_W:0]     l_r, r_r;
  logic [KW-1:0]      k_r;
  logic               lb_r, mb_r, rb_r, first_r, out_valid_r;
  logic [NODE_AW-1:0] clr_cnt_r;

  logic [95:0]        node_rdata;
  logic [31:0]        coord_rdata;
  logic [IDX_W-1:0]   coord_raddr;
  logic [IDX_W:0]     mid, rm1;

  assign mid = (l_r + r_r) >> 1;
  assign rm1 = r_r - 1'b1;

  always_comb begin
    case (cmd.csel)
      CS_L:    coord_raddr = l_r[IDX_W-1:0];
      CS_M:    coord_raddr = mid[IDX_W-1:0];
      CS_R:    coord_raddr = rm1[IDX_W-1:0];
      default: coord_raddr = slot_r;
    endcase
  end

  // add decision at one node
  logic          wl, wm, wr, both, none, go_left, node_wr, swap;
  logic [KW-1:0] k_next;
  logic [IDX_W:0] l_next, r_next;
  always_comb begin
    wl      = (lb_r == sel_min_r);
    wm      = (mb_r == sel_min_r);
    wr      = (rb_r == sel_min_r);
    both    = wl & wr;
    none    = !wl & !wr;
    go_left = (lb_r != mb_r);
    k_next  = go_left ? {k_r[KW-2:0], 1'b0} + 1'b1 : {k_r[KW-2:0], 1'b0} + KW'(2);
    l_next  = go_left ? l_r : mid;
    r_next  = go_left ? mid : r_r;
    node_wr = cmd.step & (both | (!none & wm));
    swap    = cmd.step & !both & !none & wm;
  end

  assign stat.add_stop = both | none | (k_next >= KW'(NODES)) | (r_next <= l_next);
  assign stat.k_zero   = (k_r == '0);
  assign stat.clr_last = (clr_cnt_r == NODE_AW'(NODES - 1));
  assign stat.out_busy = out_valid_r & !out_ready;

  // memories
  logic               nwe;
  logic [NODE_AW-1:0] nwaddr;
  logic [95:0]        nwdata;
  assign nwe    = cmd.clr_step | node_wr;
  assign nwaddr = cmd.clr_step ? clr_cnt_r : k_r[NODE_AW-1:0];
  assign nwdata = cmd.clr_step ? {32'd0, clr_icpt_r} : {ns_r, ni_r};

  lcht_ram #(.W(96), .D(NODES)) u_node_ram (
    .clk(clk), .we(nwe), .waddr(nwaddr), .wdata(nwdata),
    .raddr(k_r[NODE_AW-1:0]), .rdata(node_rdata)
  );

  lcht_ram #(.W(32), .D(SIZE)) u_coord_ram (
    .clk(clk), .we(cmd.coord_we), .waddr(in_index[IDX_W-1:0]), .wdata(in_coord_value),
    .raddr(coord_raddr), .rdata(coord_rdata)
  );

  // shared multiplier and evaluation
  logic signed [31:0] mul_a;
  logic signed [63:0] mul_p, v_old;
  assign mul_a = cmd.mul_old ? os_r : ns_r;
  assign mul_p = mul_a * x_r;
  assign v_old = prod_r + oi_r;

  // clear sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_icpt_r <= EMPTY_RESET;
    end else if (cmd.clr_start) begin
      clr_cnt_r  <= '0;
      clr_icpt_r <= empty_icpt_r;
    end else if (cmd.clr_step) begin
      clr_cnt_r  <= clr_cnt_r + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      ns_r   <= in_line_slope;
      ni_r   <= in_line_intercept;
      slot_r <= in_index[IDX_W-1:0];
      l_r    <= '0;
      r_r    <= (IDX_W+1)'(SIZE);
      k_r    <= '0;
    end
    if (cmd.ld_x)   x_r <= coord_rdata;
    if (cmd.ld_old) begin
      os_r <= node_rdata[95:64];
      oi_r <= node_rdata[63:0];
    end
    prod_r <= mul_p;
    if (cmd.ld_vn) vn_r <= prod_r + ni_r;
    if (cmd.ld_flag) begin
      case (cmd.flag_idx)
        2'd0:    lb_r <= (vn_r < v_old);
        2'd1:    mb_r <= (vn_r < v_old);
        default: rb_r <= (vn_r < v_old);
      endcase
    end
    if (cmd.step) begin
      if (swap) begin
        ns_r <= os_r;
        ni_r <= oi_r;
      end
      k_r <= k_next;
      l_r <= l_next;
      r_r <= r_next;
    end
    if (cmd.q_init) begin
      k_r     <= KW'(slot_r) + KW'(SIZE - 1);
      first_r <= 1'b1;
    end
    if (cmd.q_acc) begin
      first_r <= 1'b0;
      if (first_r || ((v_old < best_r) == sel_min_r)) best_r <= v_old;
    end
    if (cmd.q_up) k_r <= (k_r - 1'b1) >> 1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result data, held while the transaction waits
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= best_r;
  end
  assign out_valid      = out_valid_r;
  assign out_best_value = out_data_r;
endmodule
`default_nettype wire

/* hw/rtl/lcht_ctrl.sv */
// Controller state machine sequencing clear, write, add and query over the datapath.
// Depends on lcht_pkg.
`default_nettype none
module lcht_ctrl import lcht_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic [1:0] in_cmd,
  output logic          in_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);
  state_t     state_r, state_nxt;
  logic [1:0] j_r, j_nxt;
  logic       acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid & in_ready;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    j_nxt        = j_r;
    cmd          = '0;
    cmd.csel     = coord_sel_t'(j_r);
    cmd.flag_idx = j_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          cmd.ld_item = 1'b1;
          unique case (cmd_t'(in_cmd))
            CMD_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = S_CLR;
            end
            CMD_WRITE: cmd.coord_we = 1'b1;
            CMD_ADD: begin
              j_nxt     = '0;
              state_nxt = S_A_NODE;
            end
            default: state_nxt = S_Q_RD;
          endcase
        end
      end
      S_A_NODE: state_nxt = S_A_X;
      S_A_RD:   state_nxt = S_A_X;
      S_A_X: begin
        cmd.ld_x   = 1'b1;
        cmd.ld_old = 1'b1;
        state_nxt  = S_A_MN;
      end
      S_A_MN: state_nxt = S_A_MO;
      S_A_MO: begin
        cmd.ld_vn   = 1'b1;
        cmd.mul_old = 1'b1;
        state_nxt   = S_A_CMP;
      end
      S_A_CMP: begin
        cmd.ld_flag = 1'b1;
        if (j_r == 2'd2) begin
          state_nxt = S_A_DEC;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_A_RD;
        end
      end
      S_A_DEC: begin
        cmd.step  = 1'b1;
        j_nxt     = '0;
        state_nxt = stat.add_stop ? S_IDLE : S_A_NODE;
      end
      S_Q_RD: begin
        cmd.csel  = CS_SLOT;
        state_nxt = S_Q_X;
      end
      S_Q_X: begin
        cmd.csel   = CS_SLOT;
        cmd.ld_x   = 1'b1;
        cmd.q_init = 1'b1;
        state_nxt  = S_Q_NODE;
      end
      S_Q_NODE: state_nxt = S_Q_LD;
      S_Q_LD: begin
        cmd.ld_old = 1'b1;
        state_nxt  = S_Q_MUL;
      end
      S_Q_MUL: begin
        cmd.mul_old = 1'b1;
        state_nxt   = S_Q_ACC;
      end
      S_Q_ACC: begin
        cmd.q_acc = 1'b1;
        if (stat.k_zero) begin
          state_nxt = S_Q_OUT;
        end else begin
          cmd.q_up  = 1'b1;
          state_nxt = S_Q_NODE;
        end
      end
      S_Q_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_j_range: assert property (@(posedge clk) disable iff (!rst_n) j_r != 2'd3)
    else $error("level point counter out of range");
  a_add_start: assert property (@(posedge clk) disable iff (!rst_n)
      (acc && in_cmd == CMD_ADD) |=> state_r == S_A_NODE)
    else $error("add transaction did not start descent");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
      cmd.out_load |-> !stat.out_busy)
    else $error("result overwritten before taken");
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
      cmd.clr_step |-> (!cmd.step && !cmd.ld_item))
    else $error("node write conflict during clear");
`endif
endmodule
`default_nettype wire

/* hw/rtl/line_envelope_tree.sv */
// Li Chao tree keeping the lower or upper envelope of lines over 1024 sorted
// coordinates. An add walks at most 11 tree levels and a query visits 11
// nodes, one node at a time, as both share the single 32x32 multiplier and
// the one read port of each memory. A clear, and the clearing pass after
// reset, sweep the 2047-entry node memory one entry a cycle, during which no
// transaction is taken; config writes are always taken.
// Depends on lcht_pkg, lcht_if, lcht_ram, lcht_dp and lcht_ctrl.
`default_nettype none
module line_envelope_tree import lcht_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_wdata,
  lcht_in_if.sink          in_ch,
  lcht_out_if.source       out_ch
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  lcht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_cmd(in_ch.cmd), .in_ready(in_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  lcht_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_index(in_ch.index), .in_coord_value(in_ch.coord_value),
    .in_line_slope(in_ch.line_slope), .in_line_intercept(in_ch.line_intercept),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .out_best_value(out_ch.best_value),
    .cmd(cmd), .stat(stat)
  );
endmodule
`default_nettype wire

/* verif/tb_line_envelope_tree.sv */
// Self-checking bench for line_envelope_tree: directed table, a max-mode directed section, then random traffic.
// Depends on lcht_pkg, lcht_if and the line_envelope_tree RTL.
`default_nettype none
module tb_line_envelope_tree;
  import lcht_pkg::*;

  typedef struct {
    cmd_t              cmd;
    logic [9:0]        index;
    logic signed [31:0] coord;
    logic signed [31:0] slope;
    logic signed [63:0] icpt;
    bit                has_want;
    logic signed [63:0] want;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [63:0] cfg_wdata = '0;

  lcht_in_if  in_ch ();
  lcht_out_if out_ch ();

  line_envelope_tree dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #2 clk = ~clk;

  // Predictor state
  logic [31:0] env_slope [NODES];
  logic [63:0] env_icpt [NODES];
  logic [31:0] coords [SIZE];
  bit          keep_min;
  logic [63:0] blank_icpt;

  logic signed [63:0] want_q [$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  bit  sending = 1'b0;
  bit  forced_want = 1'b0;
  logic signed [63:0] forced_val;

  function automatic logic [63:0] line_at(logic [31:0] s, logic [63:0] b, logic [31:0] x);
    logic signed [63:0] sx, xx;
    sx = $signed(s);
    xx = $signed(x);
    return sx * xx + b;
  endfunction

  function automatic bit beats(logic [63:0] a, logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

  task automatic env_clear();
    for (int i = 0; i < NODES; i++) begin
      env_slope[i] = '0;
      env_icpt[i] = blank_icpt;
    end
  endtask

  task automatic env_add(logic [31:0] s, logic [63:0] b);
    int k, l, r, m;
    logic [31:0] os, tmp_s;
    logic [63:0] ob;
    bit lb, mb, rb;
    k = 0; l = 0; r = SIZE;
    forever begin
      m = (l + r) / 2;
      os = env_slope[k];
      ob = env_icpt[k];
      lb = beats(line_at(s, b, coords[l]), line_at(os, ob, coords[l]));
      mb = beats(line_at(s, b, coords[m]), line_at(os, ob, coords[m]));
      rb = beats(line_at(s, b, coords[r-1]), line_at(os, ob, coords[r-1]));
      if (lb == keep_min && rb == keep_min) begin
        env_slope[k] = s;
        env_icpt[k] = b;
        return;
      end
      if (lb != keep_min && rb != keep_min) return;
      if (mb == keep_min) begin
        env_slope[k] = s;
        env_icpt[k] = b;
        s = os;
        b = ob;
      end
      if (lb != mb) begin
        k = 2 * k + 1;
        r = m;
      end else begin
        k = 2 * k + 2;
        l = m;
      end
      if (k >= NODES || r <= l) return;
    end
  endtask

  function automatic logic [63:0] env_best(int slot);
    int k;
    logic [31:0] x;
    logic [63:0] best, v;
    x = coords[slot];
    k = slot + SIZE - 1;
    best = line_at(env_slope[k], env_icpt[k], x);
    while (k > 0) begin
      k = (k - 1) / 2;
      v = line_at(env_slope[k], env_icpt[k], x);
      if (beats(v, best) == keep_min) best = v;
    end
    return best;
  endfunction

  // Expectations are formed at acceptance, in transaction order
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      case (cmd_t'(in_ch.cmd))
        CMD_CLEAR: env_clear();
        CMD_WRITE: coords[in_ch.index] = in_ch.coord_value;
        CMD_ADD:   env_add(in_ch.line_slope, in_ch.line_intercept);
        default: begin
          if (forced_want && forced_val !== $signed(env_best(in_ch.index))) begin
            $display("%0t table/predictor disagree: expected %0d actual %0d", $time,
                     forced_val, $signed(env_best(in_ch.index)));
            errors++;
          end
          want_q = {want_q, (forced_want ? forced_val : $signed(env_best(in_ch.index)))};
        end
      endcase
    end
  end

  // Result checking
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (want_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %0d", $time,
                 out_ch.best_value);
        errors++;
      end else begin
        if (out_ch.best_value !== want_q[0]) begin
          $display("%0t best_value mismatch: expected %0d actual %0d", $time,
                   want_q[0], out_ch.best_value);
          errors++;
        end
        void'(want_q.pop_front());
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else case ($urandom_range(0, 3))
      0: out_ch.ready <= ($urandom_range(0, 1) == 1);
      default: out_ch.ready <= 1'b1;
    endcase
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(stim_t t);
    forced_want <= t.has_want;
    forced_val <= t.want;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= t.cmd;
    in_ch.index <= t.index;
    in_ch.coord_value <= t.coord;
    in_ch.line_slope <= t.slope;
    in_ch.line_intercept <= t.icpt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Sender bursts: a burst keeps valid high, a gap lowers it
  int burst_left = 0;
  task automatic offer(stim_t t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send(t);
  endtask

  // Wait until every result is taken and the block is idle again
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (want_q.size() != 0 || !in_ch.ready) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_t r, logic [63:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (r == CFG_SELECT_MIN) keep_min = v[0];
    else blank_icpt = v;
  endtask

  function automatic stim_t mk(cmd_t c, int idx, logic [31:0] x, logic [31:0] s,
                               logic [63:0] b);
    stim_t t;
    t.cmd = c; t.index = 10'(idx); t.coord = x; t.slope = s; t.icpt = b;
    t.has_want = 0; t.want = '0;
    return t;
  endfunction

  function automatic stim_t rand_line(int mode);
    logic [63:0] b;
    logic [31:0] s;
    s = (mode == 0) ? $urandom() : $signed($urandom_range(0, 2000)) - 1000;
    b = (mode == 0) ? {$urandom(), $urandom()}
                    : 64'($signed($urandom_range(0, 2000000)) - 1000000);
    return mk(CMD_ADD, 0, 0, s, b);
  endfunction

  stim_t dir_tab [$];
  stim_t t;
  int n;

  task automatic add_row(stim_t r);
    dir_tab = {dir_tab, r};
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_CLEAR;
    in_ch.index = '0;
    in_ch.coord_value = '0;
    in_ch.line_slope = '0;
    in_ch.line_intercept = '0;
    keep_min = 1;
    blank_icpt = EMPTY_RESET;
    env_clear();
    for (int i = 0; i < SIZE; i++) coords[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all slots written with a sorted ramp, then extremes
    for (int i = 0; i < SIZE; i++) send(mk(CMD_WRITE, i, i * 3 - 1500, 0, 0));
    t = mk(CMD_QUERY, 0, 0, 0, 0); t.has_want = 1; t.want = EMPTY_RESET;
    add_row(t);
    t = mk(CMD_QUERY, 1023, 0, 0, 0); t.has_want = 1; t.want = EMPTY_RESET;
    add_row(t);
    add_row(mk(CMD_WRITE, 1023, 32'h7fffffff, 0, 0));
    add_row(mk(CMD_WRITE, 512, 32'h0000_0005, 0, 0));
    add_row(mk(CMD_ADD, 0, 0, 32'h8000_0000, 64'h8000_0000_0000_0000));
    add_row(mk(CMD_ADD, 0, 0, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff));
    add_row(mk(CMD_ADD, 0, 0, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff));
    add_row(mk(CMD_QUERY, 1023, 32'hffff_ffff, 0, 0));
    add_row(mk(CMD_QUERY, 512, 0, 0, 0));
    add_row(mk(CMD_QUERY, 3, 0, 0, 0));
    add_row(mk(CMD_WRITE, 1023, 1569, 0, 0));
    add_row(mk(CMD_WRITE, 512, 36, 0, 0));
    add_row(mk(CMD_ADD, 0, 0, 0, 64'd1000000000000000000)); // tie with empty line
    add_row(mk(CMD_CLEAR, 0, 0, 0, 0));
    t = mk(CMD_QUERY, 700, 0, 0, 0); t.has_want = 1; t.want = EMPTY_RESET;
    add_row(t);
    foreach (dir_tab[i]) send(dir_tab[i]);
    drain();

    // Max mode, extreme empty intercept, tie favours new line
    set_reg(CFG_SELECT_MIN, 64'd0);
    set_reg(CFG_EMPTY_ICPT, 64'h8000_0000_0000_0000);
    send(mk(CMD_CLEAR, 0, 0, 0, 0));
    t = mk(CMD_QUERY, 5, 0, 0, 0); t.has_want = 1; t.want = 64'sh8000_0000_0000_0000;
    send(t);
    send(mk(CMD_ADD, 0, 0, 0, 64'h8000_0000_0000_0000));
    send(mk(CMD_ADD, 0, 0, 32'h0000_0003, 64'h7fff_ffff_ffff_ffff));
    send(mk(CMD_QUERY, 9, 0, 0, 0));
    drain();

    // Random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      set_reg(CFG_SELECT_MIN, ph % 2 == 0);
      case (ph)
        2: set_reg(CFG_EMPTY_ICPT, 64'h7fff_ffff_ffff_ffff);
        4: set_reg(CFG_EMPTY_ICPT, {$urandom(), $urandom()});
        default: set_reg(CFG_EMPTY_ICPT, ph % 2 ? -64'sd1000000000000000000
                                               : 64'sd1000000000000000000);
      endcase
      offer(mk(CMD_CLEAR, 0, 0, 0, 0));
      n = 30;
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: offer(rand_line($urandom_range(0, 2) == 0 ? 0 : 1));
          3: offer(mk(CMD_CLEAR, 0, 0, 0, 0));
          default: offer(mk(CMD_QUERY, $urandom(), 0, 0, 0));
        endcase
        // Long receiver hold-off while the sender keeps offering
        if (ph == 3 && i == 10) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (2000) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
      end
      drain();
    end

    if (errors == 0 && want_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
hw/rtl/lcht_pkg.sv
hw/rtl/lcht_if.sv
hw/rtl/lcht_ram.sv
hw/rtl/lcht_dp.sv
hw/rtl/lcht_ctrl.sv
hw/rtl/line_envelope_tree.sv
verif/tb_line_envelope_tree.sv
